// ----- rtl/core/suv_pkg.sv -----
// Package: shared constants, payload structs and state type for sort_unique_values.
package suv_pkg;

  // Store capacity and field widths
  localparam int CAPACITY = 64;
  localparam int VAL_W    = 31;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             last;
    logic             overflow;
  } out_item_t;

  // Classified work item passed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             end_mark;
    logic             ovf;
  } q_entry_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } back_state_t;

endpackage

// ----- rtl/core/suv_front.sv -----
// Front end: accepts input transactions, counts the load, drops overflow, queues work.
module suv_front
  import suv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  in_item_t item,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output q_entry_t q_wdata
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             dropped;
  logic             dropped_next;
  logic             accept;

  assign item_ready = !q_stat.full;
  assign accept     = item_valid && item_ready;

  // Classify: store, drop, or close the load
  always_comb begin
    count_next    = count;
    dropped_next  = dropped;
    q_push        = 1'b0;
    q_wdata.value = item.value;
    q_wdata.end_mark = item.end_of_set;
    q_wdata.ovf   = dropped;
    if (accept) begin
      if (item.end_of_set) begin
        // empty load gives no results, so nothing goes to the back
        q_push       = (count != '0);
        count_next   = '0;
        dropped_next = 1'b0;
      end else if (count < CNT_W'(CAPACITY)) begin
        q_push     = 1'b1;
        count_next = count + CNT_W'(1);
      end else begin
        dropped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

endmodule

// ----- rtl/core/suv_queue.sv -----
// Short FIFO that decouples the front end from the sorting back end.
module suv_queue
  import suv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output q_stat_t  stat
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign stat.full  = (fill == QCNT_W'(QDEPTH));
  assign stat.empty = (fill == '0);
  assign rdata      = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/suv_back.sv -----
// Back end: chain of sorting cells with duplicate removal, then ordered drain.
module suv_back
  import suv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  q_rdata,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  back_state_t        state;
  back_state_t        state_next;
  logic [VAL_W-1:0]   data      [CAPACITY];
  logic [VAL_W-1:0]   ins_data  [CAPACITY];
  logic [VAL_W-1:0]   shl_data  [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] ins_valid;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] eq;
  logic               hit;
  logic               insert;
  logic               mark;
  logic               emit;
  logic               ovf_hold;

  // Per-cell compare against the incoming value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = valid[i] && (data[i] > q_rdata.value);
      eq[i] = valid[i] && (data[i] == q_rdata.value);
    end
  end
  assign hit = |eq;

  // Insert: cells above the slot shift up, the slot takes the new value
  always_comb begin
    ins_data[0]  = (gt[0] || !valid[0]) ? q_rdata.value : data[0];
    ins_valid[0] = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      ins_data[i]  = gt[i-1] ? data[i-1] :
                     (gt[i] || !valid[i]) ? q_rdata.value : data[i];
      ins_valid[i] = valid[i] | valid[i-1];
    end
  end

  // Drain: chain moves down one cell per result
  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      shl_data[i] = data[i+1];
    end
    shl_data[CAPACITY-1] = data[CAPACITY-1];
  end

  // Control outputs
  always_comb begin
    q_pop  = (state == ST_LOAD) && !q_stat.empty;
    insert = q_pop && !q_rdata.end_mark && !hit;
    mark   = q_pop && q_rdata.end_mark;
    emit   = (state == ST_DRAIN) && valid[0] && (!result_valid || result_ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (mark) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (emit && !valid[1]) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Cell chain
  always_ff @(posedge clk) begin
    if (insert) begin
      data <= ins_data;
    end else if (emit) begin
      data <= shl_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (insert) begin
      valid <= ins_valid;
    end else if (emit) begin
      valid <= {1'b0, valid[CAPACITY-1:1]};
    end
  end

  // Overflow flag of the current run
  always_ff @(posedge clk) begin
    if (mark) begin
      ovf_hold <= q_rdata.ovf;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      result.sorted_value <= data[0];
      result.last         <= !valid[1];
      result.overflow     <= ovf_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/sort_unique_values.sv -----
// Top level: sort_unique_values, front end, work queue and sorting back end.
//
//  channel  signals                             payload     transaction when
//  input    item_valid / item_ready / item      in_item_t   valid & ready
//  output   result_valid / result_ready / result out_item_t valid & ready
//
// A value transaction is written into the 4-entry queue and, while the back end is
// loading, leaves the queue and enters the cell chain. An end marker starts a drain
// of the N distinct values, one result per cycle unless the output stalls, set by the
// single output register; meanwhile the front takes transactions until the queue fills.
// Reset is synchronous and clears control and valid bits only; no clearing pass.
// An output stall holds the drain; a full queue drops item_ready.
module sort_unique_values
  import suv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  logic     q_push;
  logic     q_pop;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  q_stat_t  q_stat;

  suv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  suv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  suv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rdata      (q_rdata),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Queue never written when full
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_stat.full)
    else $error("queue push while full");

  // Queue never read when empty
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // A run continues without a gap until its last result
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !result.last) |=> result_valid)
    else $error("gap inside a sorted run");

endmodule

// ----- bench/tb.sv -----
// Testbench for sort_unique_values: directed and random load runs checked against a sorting predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import suv_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 85;
  localparam int TAIL_CYCLES = 100;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  // Stimulus not yet driven and results not yet seen
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  // Predictor state: values held in the current load and the drop flag
  logic [VAL_W-1:0] load_values[$];
  logic             load_dropped = 1'b0;

  int   items_queued = 0;
  int   items_taken = 0;
  int   quiet_cycles = 0;
  int   error_count = 0;
  int   send_gap_pct = 7;
  int   recv_stall_pct = 54;
  logic item_accepted = 1'b0;

  sort_unique_values dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor: values collect until an end marker, which releases the
  // distinct values in ascending order
  function automatic void absorb_item(input in_item_t it);
    logic [VAL_W-1:0] run_vals[$];
    int               pos;
    out_item_t        res;
    if (!it.end_of_set) begin
      if (load_values.size() < CAPACITY) load_values.push_back(it.value);
      else load_dropped = 1'b1;
    end else begin
      foreach (load_values[i]) begin
        pos = 0;
        while (pos < run_vals.size() && run_vals[pos] < load_values[i]) pos++;
        if (pos == run_vals.size() || run_vals[pos] != load_values[i])
          run_vals.insert(pos, load_values[i]);
      end
      foreach (run_vals[i]) begin
        res.sorted_value = run_vals[i];
        res.last         = (i == run_vals.size() - 1);
        res.overflow     = load_dropped;
        expected_results.push_back(res);
      end
      load_values.delete();
      load_dropped = 1'b0;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, got %h/%b/%b", $time,
               got.sorted_value, got.last, got.overflow);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.sorted_value != want.sorted_value) begin
        $display("%0t: sorted_value expected %h, got %h", $time,
                 want.sorted_value, got.sorted_value);
        error_count++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %b, got %b", $time, want.last, got.last);
        error_count++;
      end
      if (got.overflow != want.overflow) begin
        $display("%0t: overflow expected %b, got %b", $time, want.overflow, got.overflow);
        error_count++;
      end
    end
  endfunction

  function automatic void queue_item(input logic [VAL_W-1:0] v, input logic eos);
    in_item_t it;
    it.value      = v;
    it.end_of_set = eos;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  // One load: n values of a random flavor, then an end marker with junk value bits
  function automatic void queue_load(input int n_values);
    int               style;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    style = $urandom_range(3);
    base  = VAL_W'($urandom());
    for (int i = 0; i < n_values; i++) begin
      case (style)
        0: v = VAL_W'($urandom());
        1: v = VAL_W'($urandom_range(15));
        2: begin
          case ($urandom_range(3))
            0: v = '0;
            1: v = VAL_MAX;
            2: v = VAL_MAX - VAL_W'(1);
            default: v = VAL_W'($urandom());
          endcase
        end
        default: v = base ^ VAL_W'($urandom_range(3));
      endcase
      queue_item(v, 1'b0);
    end
    queue_item(VAL_W'($urandom()), 1'b1);
  endfunction

  // Mostly short loads, some empty ones, a few longer ones
  function automatic void fill_phase(input int budget);
    int start;
    int pick;
    start = items_queued;
    while (items_queued - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) queue_load(0);
      else if (pick < 70) queue_load($urandom_range(8, 1));
      else if (pick < 90) queue_load($urandom_range(24, 9));
      else queue_load($urandom_range(40, 25));
    end
  endfunction

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    item_accepted <= item_valid && item_ready;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (result_valid && result_ready) check_result(result);
      if (item_valid && item_ready) begin
        absorb_item(item);
        items_taken <= items_taken + 1;
      end
      if ((result_valid && result_ready) || (item_valid && item_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Driver: new transaction or gap at the falling edge, receiver stalls at random
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || item_accepted) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long with no transaction on either channel
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    // Directed: extremes, duplicates, ignored value on end marker
    queue_item('0, 1'b0);
    queue_item(VAL_MAX, 1'b0);
    queue_item(31'd5, 1'b0);
    queue_item(31'd5, 1'b0);
    queue_item('0, 1'b0);
    queue_item(VAL_MAX, 1'b1);
    // end marker on an empty store
    queue_item(31'h2AAAAAAA, 1'b1);
    // single value
    queue_item(VAL_MAX, 1'b0);
    queue_item('0, 1'b1);
    // all the same
    repeat (4) queue_item(31'd9, 1'b0);
    queue_item(31'h55555555, 1'b1);
    // descending input, bit patterns around the middle
    queue_item(31'h40000000, 1'b0);
    queue_item(31'h3FFFFFFF, 1'b0);
    queue_item(31'd2, 1'b0);
    queue_item(31'd1, 1'b0);
    queue_item(VAL_MAX, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 1: sender rarely idles, receiver stalls often
    fill_phase(PHASE_ITEMS);
    while (items_taken != items_queued) @(negedge clk);

    // Phase 2: the other way round; a load that fills the store exactly
    send_gap_pct   = 54;
    recv_stall_pct = 7;
    queue_load(CAPACITY);
    fill_phase(PHASE_ITEMS);
    while (items_taken != items_queued) @(negedge clk);

    // Phase 3: full rate; a load that overruns the store
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    queue_load(CAPACITY + $urandom_range(8, 1));
    fill_phase(PHASE_ITEMS);

    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
